// ===== src/mlfq_pkg.sv =====
package mlfq_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LOAD_W = 21;
  localparam int DVD_W  = 53;
  localparam int DVS_W  = 22;
  localparam int CNT_W  = $clog2(DVD_W + 1);

  typedef enum logic [2:0] {
    K_TICK     = 3'd0,
    K_SECOND   = 3'd1,
    K_SET_NICE = 3'd2,
    K_CREATE   = 3'd3,
    K_EXIT     = 3'd4,
    K_QUERY    = 3'd5,
    K_RESTART  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    R_ENABLE    = 3'd0,
    R_PRIO_LOW  = 3'd1,
    R_PRIO_HIGH = 3'd2,
    R_NICE_LOW  = 3'd3,
    R_NICE_HIGH = 3'd4,
    R_SLICE     = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TK_RD,
    ST_TK_WR,
    ST_PR_RD,
    ST_PR_WR,
    ST_LD_DIV,
    ST_DC_RD,
    ST_DC_MUL,
    ST_DC_DIV,
    ST_DC_WR,
    ST_SN_RD,
    ST_SN_WR,
    ST_CR_RD,
    ST_CR_WR,
    ST_OUT_RD,
    ST_OUT_CAP
  } state_e;

  typedef struct packed {
    logic signed [5:0]  nice;
    logic signed [31:0] cpu;
    logic [5:0]         prio;
  } entry_t;

endpackage

// ===== src/mlfq_priority_scheduler_math.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   kind, slot, running_idle, parent_slot,
//                                                nice_request, ready_count
// out       output     out_valid_o / out_ready_i yield_now, slot_priority, slot_nice,
//                                                cpu_times_100, load_times_100
// apb       input      psel, penable, pwrite     six registers at byte address 4*i
//
// Slot state lives in one 64-entry memory with a registered read; every access is
// a read followed by a write-back. Query, exit and restart, and a second while the
// scheduler is disabled, only read the slot for the result. When the slice ends with
// the scheduler enabled a tick also recomputes the priority of every valid slot, and
// an enabled second runs a bit-serial divide of the cpu decay for each valid slot.
// After reset the block is ready at once; a result that waits on out_ready_i holds
// the next item in its last step.
module mlfq_priority_scheduler_math (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          kind_i,
  input  logic [5:0]          slot_i,
  input  logic                running_idle_i,
  input  logic [5:0]          parent_slot_i,
  input  logic signed [15:0]  nice_request_i,
  input  logic [6:0]          ready_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                yield_now_o,
  output logic [5:0]          slot_priority_o,
  output logic signed [5:0]   slot_nice_o,
  output logic signed [31:0]  cpu_times_100_o,
  output logic [12:0]         load_times_100_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [mlfq_pkg::SLOT_W-1:0] LastSlot = mlfq_pkg::SLOT_W'(mlfq_pkg::SLOTS - 1);
  // ceil(2^28 / 15): exact floor division by 15 for any 24-bit dividend.
  localparam logic [24:0] LoadRecip = 25'd17895698;

  // Configuration registers
  logic             en_q;
  logic [5:0]       prio_low_q, prio_high_q;
  logic [5:0]       nice_low_q;
  logic [4:0]       nice_high_q;
  logic [7:0]       slice_ticks_q;

  // Control state
  mlfq_pkg::state_e state_q, state_d;
  logic [mlfq_pkg::SLOTS-1:0] valid_q, written_q;
  logic [mlfq_pkg::SLOT_W-1:0] idx_q;
  logic [7:0]       slice_q;
  logic [mlfq_pkg::LOAD_W-1:0] load_q;
  logic             yield_q;

  // Latched item
  logic [mlfq_pkg::SLOT_W-1:0] slot_q, parent_q;
  logic             idle_q;
  logic signed [15:0] req_q;
  logic [25:0]      ld_dvd_q;

  // Memory
  mlfq_pkg::entry_t mem [mlfq_pkg::SLOTS];
  mlfq_pkg::entry_t rd_q, ent, wd;
  logic             rd_en, we, rd_wr_q;
  logic [mlfq_pkg::SLOT_W-1:0] rd_addr, rd_addr_q, wa;

  // Divider
  logic [mlfq_pkg::DVD_W-1:0] quo_q, div_dvd;
  logic [mlfq_pkg::DVS_W-1:0] dvs_q, div_dvs;
  logic [mlfq_pkg::DVS_W-1:0] rem_q;
  logic [mlfq_pkg::CNT_W-1:0] cnt_q;
  logic [mlfq_pkg::DVS_W:0]   rem_sh;
  logic             rem_ge, div_start, dc_neg_q;

  // Output register
  logic             out_load;

  logic             accept, charge, set_valid, load_we, idx_step;
  logic [7:0]       slice_inc;
  logic [25:0]      load_dvd;
  logic [48:0]      ld_prod;
  logic [6:0]       ready_sat;
  logic signed [32:0] tick_sum;
  logic signed [31:0] tick_cpu, dc_cpu;
  logic [31:0]      cpu_mag;
  logic signed [32:0] dc_q;
  logic signed [33:0] dc_sum;
  logic signed [15:0] nice_lo16, nice_hi16;
  logic signed [5:0]  nice_cl;
  logic signed [38:0] x100;
  logic [38:0]      x100_mag;
  logic [31:0]      c100_mag;
  logic [27:0]      l100;

  function automatic logic [5:0] prio_f(input logic signed [31:0] cpu,
                                        input logic signed [5:0] nice,
                                        input logic [5:0] pl, input logic [5:0] ph);
    logic [32:0]        mag;
    logic [32:0]        c4;
    logic [18:0]        rm;
    logic signed [19:0] r;
    logic signed [19:0] p;
    mag = cpu[31] ? (33'd0 - {cpu[31], cpu}) : {1'b0, cpu};
    c4  = mag >> 2;
    rm  = 19'((c4 + 33'd8192) >> 14);
    r   = cpu[31] ? (20'sd0 - $signed(20'(rm))) : $signed(20'(rm));
    p   = $signed({14'd0, ph}) - r - ($signed({{14{nice[5]}}, nice}) <<< 1);
    if (p < $signed({14'd0, pl})) begin
      prio_f = pl;
    end else if (p > $signed({14'd0, ph})) begin
      prio_f = ph;
    end else begin
      prio_f = p[5:0];
    end
  endfunction

  assign pready     = 1'b1;
  assign accept     = in_valid_i && in_ready_o;
  assign slice_inc  = (slice_q == 8'd255) ? slice_q : slice_q + 8'd1;
  assign ready_sat  = (ready_count_i > 7'd64) ? 7'd64 : ready_count_i;
  assign load_dvd   = 26'(load_q) * 26'd59 + (26'(ready_sat) << 14);
  // Division by 60 is a shift by two followed by a reciprocal multiply by 1/15.
  assign ld_prod    = 49'(ld_dvd_q[25:2]) * 49'(LoadRecip);
  assign charge     = en_q && !idle_q && valid_q[slot_q];

  // An entry never written reads as its reset value.
  always_comb begin
    if (rd_wr_q) begin
      ent = rd_q;
    end else begin
      ent.nice = '0;
      ent.cpu  = '0;
      ent.prio = (rd_addr_q == '0) ? 6'd31 : 6'd0;
    end
  end

  assign tick_sum = {ent.cpu[31], ent.cpu} + 33'sd16384;
  assign tick_cpu = (tick_sum > 33'sd2147483647) ? 32'sh7fffffff : tick_sum[31:0];
  assign cpu_mag  = ent.cpu[31] ? (32'd0 - ent.cpu) : ent.cpu;

  assign dc_q   = dc_neg_q ? (33'sd0 - $signed({1'b0, quo_q[31:0]}))
                           : $signed({1'b0, quo_q[31:0]});
  assign dc_sum = ($signed({dc_q[32], dc_q}) <<< 1)
                + ($signed({{28{ent.nice[5]}}, ent.nice}) <<< 14);
  always_comb begin
    if (dc_sum > 34'sd2147483647) begin
      dc_cpu = 32'sh7fffffff;
    end else if (dc_sum < -34'sd2147483648) begin
      dc_cpu = 32'sh80000000;
    end else begin
      dc_cpu = dc_sum[31:0];
    end
  end

  assign nice_lo16 = $signed({{10{nice_low_q[5]}}, nice_low_q});
  assign nice_hi16 = $signed({11'd0, nice_high_q});
  always_comb begin
    if (req_q < nice_lo16) begin
      nice_cl = nice_lo16[5:0];
    end else if (req_q > nice_hi16) begin
      nice_cl = nice_hi16[5:0];
    end else begin
      nice_cl = req_q[5:0];
    end
  end

  assign x100     = $signed({{7{ent.cpu[31]}}, ent.cpu}) * 39'sd100;
  assign x100_mag = x100[38] ? (39'd0 - x100) : x100;
  assign c100_mag = 32'((x100_mag + 39'd8192) >> 14);
  assign l100     = (28'(load_q) * 28'd100 + 28'd8192) >> 14;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlfq_pkg::ST_IDLE: begin
        if (accept) begin
          case (mlfq_pkg::kind_e'(kind_i))
            mlfq_pkg::K_TICK:     state_d = mlfq_pkg::ST_TK_RD;
            mlfq_pkg::K_SECOND:   state_d = en_q ? mlfq_pkg::ST_LD_DIV : mlfq_pkg::ST_OUT_RD;
            mlfq_pkg::K_SET_NICE: state_d = mlfq_pkg::ST_SN_RD;
            mlfq_pkg::K_CREATE:   state_d = mlfq_pkg::ST_CR_RD;
            default:              state_d = mlfq_pkg::ST_OUT_RD;
          endcase
        end
      end
      mlfq_pkg::ST_TK_RD: begin
        if (charge) begin
          state_d = mlfq_pkg::ST_TK_WR;
        end else begin
          state_d = (yield_q && en_q) ? mlfq_pkg::ST_PR_RD : mlfq_pkg::ST_OUT_RD;
        end
      end
      mlfq_pkg::ST_TK_WR:
        state_d = (yield_q && en_q) ? mlfq_pkg::ST_PR_RD : mlfq_pkg::ST_OUT_RD;
      mlfq_pkg::ST_PR_RD: begin
        if (valid_q[idx_q]) begin
          state_d = mlfq_pkg::ST_PR_WR;
        end else if (idx_q == LastSlot) begin
          state_d = mlfq_pkg::ST_OUT_RD;
        end
      end
      mlfq_pkg::ST_PR_WR:
        state_d = (idx_q == LastSlot) ? mlfq_pkg::ST_OUT_RD : mlfq_pkg::ST_PR_RD;
      mlfq_pkg::ST_LD_DIV: state_d = mlfq_pkg::ST_DC_RD;
      mlfq_pkg::ST_DC_RD: begin
        if (valid_q[idx_q]) begin
          state_d = mlfq_pkg::ST_DC_MUL;
        end else if (idx_q == LastSlot) begin
          state_d = mlfq_pkg::ST_OUT_RD;
        end
      end
      mlfq_pkg::ST_DC_MUL: state_d = mlfq_pkg::ST_DC_DIV;
      mlfq_pkg::ST_DC_DIV: begin
        if (cnt_q == '0) state_d = mlfq_pkg::ST_DC_WR;
      end
      mlfq_pkg::ST_DC_WR:
        state_d = (idx_q == LastSlot) ? mlfq_pkg::ST_OUT_RD : mlfq_pkg::ST_DC_RD;
      mlfq_pkg::ST_SN_RD:
        state_d = valid_q[slot_q] ? mlfq_pkg::ST_SN_WR : mlfq_pkg::ST_OUT_RD;
      mlfq_pkg::ST_SN_WR:  state_d = mlfq_pkg::ST_OUT_RD;
      mlfq_pkg::ST_CR_RD:  state_d = mlfq_pkg::ST_CR_WR;
      mlfq_pkg::ST_CR_WR:  state_d = mlfq_pkg::ST_OUT_RD;
      mlfq_pkg::ST_OUT_RD: state_d = mlfq_pkg::ST_OUT_CAP;
      mlfq_pkg::ST_OUT_CAP: begin
        if (out_load) state_d = mlfq_pkg::ST_IDLE;
      end
      default: state_d = mlfq_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = slot_q;
    we         = 1'b0;
    wa         = slot_q;
    wd         = ent;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    set_valid  = 1'b0;
    load_we    = 1'b0;
    idx_step   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      mlfq_pkg::ST_IDLE: in_ready_o = 1'b1;
      mlfq_pkg::ST_TK_RD: rd_en = charge;
      mlfq_pkg::ST_TK_WR: begin
        we     = 1'b1;
        wd.cpu = tick_cpu;
      end
      mlfq_pkg::ST_PR_RD: begin
        rd_en    = valid_q[idx_q];
        rd_addr  = idx_q;
        idx_step = !valid_q[idx_q];
      end
      mlfq_pkg::ST_PR_WR: begin
        we       = 1'b1;
        wa       = idx_q;
        wd.prio  = prio_f(ent.cpu, ent.nice, prio_low_q, prio_high_q);
        idx_step = 1'b1;
      end
      mlfq_pkg::ST_LD_DIV: load_we = 1'b1;
      mlfq_pkg::ST_DC_RD: begin
        rd_en    = valid_q[idx_q];
        rd_addr  = idx_q;
        idx_step = !valid_q[idx_q];
      end
      mlfq_pkg::ST_DC_MUL: begin
        div_start = 1'b1;
        div_dvd   = mlfq_pkg::DVD_W'(cpu_mag) * mlfq_pkg::DVD_W'(load_q);
        div_dvs   = (mlfq_pkg::DVS_W'(load_q) << 1) + mlfq_pkg::DVS_W'(16384);
      end
      mlfq_pkg::ST_DC_WR: begin
        we       = 1'b1;
        wa       = idx_q;
        wd.cpu   = dc_cpu;
        idx_step = 1'b1;
      end
      mlfq_pkg::ST_SN_RD: rd_en = valid_q[slot_q];
      mlfq_pkg::ST_SN_WR: begin
        we      = 1'b1;
        wd.nice = nice_cl;
        if (en_q) wd.prio = prio_f(ent.cpu, nice_cl, prio_low_q, prio_high_q);
      end
      mlfq_pkg::ST_CR_RD: begin
        rd_en   = 1'b1;
        rd_addr = parent_q;
      end
      mlfq_pkg::ST_CR_WR: begin
        we        = 1'b1;
        set_valid = 1'b1;
      end
      mlfq_pkg::ST_OUT_RD: rd_en = 1'b1;
      mlfq_pkg::ST_OUT_CAP: out_load = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  // Slot memory
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign rem_sh = {rem_q, quo_q[mlfq_pkg::DVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (div_start) begin
      cnt_q <= mlfq_pkg::CNT_W'(mlfq_pkg::DVD_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      quo_q    <= div_dvd;
      dvs_q    <= div_dvs;
      rem_q    <= '0;
      dc_neg_q <= ent.cpu[31];
    end else if (cnt_q != '0) begin
      rem_q <= rem_ge ? mlfq_pkg::DVS_W'(rem_sh - {1'b0, dvs_q})
                      : mlfq_pkg::DVS_W'(rem_sh);
      quo_q <= {quo_q[mlfq_pkg::DVD_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q   <= slot_i;
      parent_q <= parent_slot_i;
      idle_q   <= running_idle_i;
      req_q    <= nice_request_i;
      ld_dvd_q <= load_dvd;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
      rd_wr_q   <= written_q[rd_addr] || (we && wa == rd_addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mlfq_pkg::ST_IDLE;
      valid_q       <= mlfq_pkg::SLOTS'(1);
      written_q     <= '0;
      idx_q         <= '0;
      slice_q       <= '0;
      load_q        <= '0;
      yield_q       <= 1'b0;
      out_valid_o   <= 1'b0;
      en_q          <= 1'b0;
      prio_low_q    <= 6'd0;
      prio_high_q   <= 6'd63;
      nice_low_q    <= 6'h2c;
      nice_high_q   <= 5'd20;
      slice_ticks_q <= 8'd4;
    end else begin
      state_q <= state_d;
      if (we) written_q[wa] <= 1'b1;
      if (set_valid) valid_q[slot_q] <= 1'b1;
      if (load_we) load_q <= ld_prod[48:28];
      if (idx_step) idx_q <= idx_q + 1'b1;
      if (accept) begin
        idx_q   <= '0;
        yield_q <= (mlfq_pkg::kind_e'(kind_i) == mlfq_pkg::K_TICK) &&
                   (slice_inc >= slice_ticks_q);
        case (mlfq_pkg::kind_e'(kind_i))
          mlfq_pkg::K_TICK:    slice_q <= slice_inc;
          mlfq_pkg::K_EXIT:    valid_q[slot_i] <= 1'b0;
          mlfq_pkg::K_RESTART: slice_q <= '0;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        case (mlfq_pkg::reg_e'(paddr[4:2]))
          mlfq_pkg::R_ENABLE:    en_q          <= pwdata[0];
          mlfq_pkg::R_PRIO_LOW:  prio_low_q    <= pwdata[5:0];
          mlfq_pkg::R_PRIO_HIGH: prio_high_q   <= pwdata[5:0];
          mlfq_pkg::R_NICE_LOW:  nice_low_q    <= pwdata[5:0];
          mlfq_pkg::R_NICE_HIGH: nice_high_q   <= pwdata[4:0];
          mlfq_pkg::R_SLICE:     slice_ticks_q <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      yield_now_o      <= yield_q;
      slot_priority_o  <= ent.prio;
      slot_nice_o      <= ent.nice;
      cpu_times_100_o  <= x100[38] ? (32'sd0 - $signed(c100_mag)) : $signed(c100_mag);
      load_times_100_o <= l100[12:0];
    end
  end

  always_comb begin
    case (mlfq_pkg::reg_e'(paddr[4:2]))
      mlfq_pkg::R_ENABLE:    prdata = {31'd0, en_q};
      mlfq_pkg::R_PRIO_LOW:  prdata = {26'd0, prio_low_q};
      mlfq_pkg::R_PRIO_HIGH: prdata = {26'd0, prio_high_q};
      mlfq_pkg::R_NICE_LOW:  prdata = {26'd0, nice_low_q};
      mlfq_pkg::R_NICE_HIGH: prdata = {27'd0, nice_high_q};
      mlfq_pkg::R_SLICE:     prdata = {24'd0, slice_ticks_q};
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== src/mlfq_checker.sv =====
module mlfq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [12:0] load_times_100_o,
  input logic        pready
);

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // One item at a time: a transfer in closes the input until its result is built.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A result always needs at least a memory read after its item is taken.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> load_times_100_o <= 13'd6400)
    else $error("load average out of range");

endmodule

bind mlfq_priority_scheduler_math mlfq_checker u_mlfq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .load_times_100_o (load_times_100_o),
  .pready           (pready)
);

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] K_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 20000;
  localparam int N_PHASES = 6;

  typedef struct packed {
    logic               yield_now;
    logic [5:0]         prio;
    logic signed [5:0]  nice;
    logic signed [31:0] cpu100;
    logic [12:0]        load100;
  } sched_result_t;

  typedef struct {
    logic [2:0]         kind;
    logic [5:0]         slot;
    logic               idle;
    logic [5:0]         parent;
    logic signed [15:0] nice_req;
    logic [6:0]         ready;
    bit                 typed;
    sched_result_t      res;
  } event_row_t;

  typedef struct {
    bit                 enable;
    logic [5:0]         prio_lo;
    logic [5:0]         prio_hi;
    logic signed [5:0]  nice_lo;
    logic [4:0]         nice_hi;
    logic [7:0]         slice;
  } sched_cfg_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [2:0]          kind_i = '0;
  logic [5:0]          slot_i = '0;
  logic                running_idle_i = 1'b0;
  logic [5:0]          parent_slot_i = '0;
  logic signed [15:0]  nice_request_i = '0;
  logic [6:0]          ready_count_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                yield_now_o;
  logic [5:0]          slot_priority_o;
  logic signed [5:0]   slot_nice_o;
  logic signed [31:0]  cpu_times_100_o;
  logic [12:0]         load_times_100_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [4:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Typed expectation travelling with the item on the input channel.
  bit                  row_typed = 1'b0;
  sched_result_t       row_res = '0;

  bit                  calm = 1'b0;
  int                  errors = 0;
  int                  quiet_cycles = 0;
  sched_result_t       pending_results[$];

  // Scheduler shadow state.
  bit                  cfg_enable;
  logic [5:0]          cfg_prio_lo, cfg_prio_hi;
  logic signed [5:0]   cfg_nice_lo;
  logic [4:0]          cfg_nice_hi;
  logic [7:0]          cfg_slice;
  bit                  slot_live[mlfq_pkg::SLOTS];
  logic signed [31:0]  cpu_fx[mlfq_pkg::SLOTS];
  logic signed [5:0]   nice_val[mlfq_pkg::SLOTS];
  logic [5:0]          prio_val[mlfq_pkg::SLOTS];
  longint              load_fx;
  int                  slice_cnt;

  mlfq_priority_scheduler_math uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint round_fx(longint x);
    return (x > 0) ? (x + 8192) / 16384 : (x - 8192) / 16384;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic void reprioritize(int s);
    longint p;
    p = longint'(cfg_prio_hi) - round_fx(longint'(cpu_fx[s]) / 4)
        - 2 * longint'(nice_val[s]);
    if (p < longint'(cfg_prio_lo)) p = longint'(cfg_prio_lo);
    else if (p > longint'(cfg_prio_hi)) p = longint'(cfg_prio_hi);
    prio_val[s] = p[5:0];
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < mlfq_pkg::SLOTS; i++) begin
      slot_live[i] = 1'b0;
      cpu_fx[i] = '0;
      nice_val[i] = '0;
      prio_val[i] = '0;
    end
    slot_live[0] = 1'b1;
    prio_val[0] = 6'd31;
    load_fx = 0;
    slice_cnt = 0;
    cfg_enable = 1'b0;
    cfg_prio_lo = 6'd0;
    cfg_prio_hi = 6'd63;
    cfg_nice_lo = -6'sd20;
    cfg_nice_hi = 5'd20;
    cfg_slice = 8'd4;
  endfunction

  function automatic sched_result_t schedule_event(logic [2:0] kind, logic [5:0] s,
                                                   logic idle, logic [5:0] par,
                                                   logic signed [15:0] nreq,
                                                   logic [6:0] ready);
    sched_result_t r;
    longint req, lo, hi, rdy, q;
    r = '0;
    case (kind)
      mlfq_pkg::K_TICK: begin
        if (cfg_enable && !idle && slot_live[s])
          cpu_fx[s] = clip32(longint'(cpu_fx[s]) + 16384);
        if (slice_cnt < 255) slice_cnt++;
        if (slice_cnt >= int'(cfg_slice)) begin
          if (cfg_enable)
            for (int i = 0; i < mlfq_pkg::SLOTS; i++) if (slot_live[i]) reprioritize(i);
          r.yield_now = 1'b1;
        end
      end
      mlfq_pkg::K_SECOND: begin
        if (cfg_enable) begin
          rdy = (ready > 7'd64) ? 64 : longint'(ready);
          load_fx = (59 * load_fx + rdy * 16384) / 60;
          for (int i = 0; i < mlfq_pkg::SLOTS; i++) begin
            if (slot_live[i]) begin
              q = (longint'(cpu_fx[i]) * load_fx) / (2 * load_fx + 16384);
              cpu_fx[i] = clip32(2 * q + longint'(nice_val[i]) * 16384);
            end
          end
        end
      end
      mlfq_pkg::K_SET_NICE: begin
        if (slot_live[s]) begin
          req = longint'(nreq);
          lo = longint'(cfg_nice_lo);
          hi = longint'(cfg_nice_hi);
          if (req < lo) req = lo;
          else if (req > hi) req = hi;
          nice_val[s] = req[5:0];
          if (cfg_enable) reprioritize(s);
        end
      end
      mlfq_pkg::K_CREATE: begin
        slot_live[s] = 1'b1;
        nice_val[s] = nice_val[par];
        cpu_fx[s] = cpu_fx[par];
        prio_val[s] = prio_val[par];
      end
      mlfq_pkg::K_EXIT: slot_live[s] = 1'b0;
      mlfq_pkg::K_RESTART: slice_cnt = 0;
      default: ;
    endcase
    r.prio = prio_val[s];
    r.nice = nice_val[s];
    q = clip32(round_fx(100 * longint'(cpu_fx[s])));
    r.cpu100 = q[31:0];
    q = round_fx(100 * load_fx);
    r.load100 = q[12:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    sched_result_t got, want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = schedule_event(kind_i, slot_i, running_idle_i, parent_slot_i,
                              nice_request_i, ready_count_i);
        pending_results.push_back(row_typed ? row_res : want);
      end
      if (out_valid_o && out_ready_i) begin
        got = '{yield_now_o, slot_priority_o, slot_nice_o, cpu_times_100_o,
                load_times_100_o};
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $realtime, got);
        end else begin
          want = pending_results.pop_front();
          if (got.yield_now !== want.yield_now || got.prio !== want.prio ||
              got.nice !== want.nice || got.cpu100 !== want.cpu100 ||
              got.load100 !== want.load100) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Leaves psel high so that writes can follow each other; apply_config closes it.
  task automatic write_reg(mlfq_pkg::reg_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      mlfq_pkg::R_ENABLE:    cfg_enable = value[0];
      mlfq_pkg::R_PRIO_LOW:  cfg_prio_lo = value[5:0];
      mlfq_pkg::R_PRIO_HIGH: cfg_prio_hi = value[5:0];
      mlfq_pkg::R_NICE_LOW:  cfg_nice_lo = value[5:0];
      mlfq_pkg::R_NICE_HIGH: cfg_nice_hi = value[4:0];
      mlfq_pkg::R_SLICE:     cfg_slice = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(sched_cfg_t c);
    write_reg(mlfq_pkg::R_ENABLE, 32'(c.enable));
    write_reg(mlfq_pkg::R_PRIO_LOW, 32'(c.prio_lo));
    write_reg(mlfq_pkg::R_PRIO_HIGH, 32'(c.prio_hi));
    write_reg(mlfq_pkg::R_NICE_LOW, 32'(unsigned'(c.nice_lo)));
    write_reg(mlfq_pkg::R_NICE_HIGH, 32'(c.nice_hi));
    write_reg(mlfq_pkg::R_SLICE, 32'(c.slice));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic issue_event(event_row_t e);
    in_valid_i <= 1'b1;
    kind_i <= e.kind;
    slot_i <= e.slot;
    running_idle_i <= e.idle;
    parent_slot_i <= e.parent;
    nice_request_i <= e.nice_req;
    ready_count_i <= e.ready;
    row_typed <= e.typed;
    row_res <= e.res;
    do @(posedge clk_i); while (!in_ready_o);
    if (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic event_row_t random_event();
    event_row_t e;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) e.kind = mlfq_pkg::K_TICK;
    else if (pick < 52) e.kind = mlfq_pkg::K_SECOND;
    else if (pick < 67) e.kind = mlfq_pkg::K_SET_NICE;
    else if (pick < 77) e.kind = mlfq_pkg::K_CREATE;
    else if (pick < 84) e.kind = mlfq_pkg::K_EXIT;
    else if (pick < 94) e.kind = mlfq_pkg::K_QUERY;
    else if (pick < 98) e.kind = mlfq_pkg::K_RESTART;
    else e.kind = K_UNUSED;
    // Most traffic stays on a few slots so that they live long enough to matter.
    e.slot = ($urandom_range(3) != 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    e.parent = ($urandom_range(3) != 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    e.idle = ($urandom_range(3) == 0);
    e.nice_req = $urandom_range(1) ? 16'(int'($urandom_range(80)) - 40) : 16'($urandom);
    e.ready = 7'($urandom_range(127));
    e.typed = 1'b0;
    e.res = '0;
    return e;
  endfunction

  event_row_t directed[$];
  sched_cfg_t phases[N_PHASES];

  initial begin
    clear_shadow();
    phases[0] = '{1'b1, 6'd0, 6'd63, -6'sd20, 5'd20, 8'd4};
    phases[1] = '{1'b1, 6'd0, 6'd63, -6'sd31, 5'd31, 8'd1};
    phases[2] = '{1'b0, 6'd10, 6'd40, -6'sd5, 5'd5, 8'd2};
    phases[3] = '{1'b1, 6'd63, 6'd0, 6'sd0, 5'd0, 8'd255};
    phases[4] = '{1'b1, 6'd20, 6'd50, -6'sd31, 5'd0, 8'd7};
    phases[5] = '{1'b1, 6'd0, 6'd63, -6'sd20, 5'd20, 8'd3};

    directed = '{
      '{mlfq_pkg::K_QUERY, 6'd0, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b1,
        '{1'b0, 6'd31, 6'sd0, 32'sd0, 13'd0}},
      '{mlfq_pkg::K_QUERY, 6'd63, 1'b1, 6'd63, -16'sd1, 7'd127, 1'b1, '0},
      '{mlfq_pkg::K_TICK, 6'd0, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_TICK, 6'd0, 1'b1, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_CREATE, 6'd1, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_SET_NICE, 6'd1, 1'b0, 6'd0, 16'sd32767, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_SET_NICE, 6'd1, 1'b0, 6'd0, 16'sh8000, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_SET_NICE, 6'd40, 1'b0, 6'd0, 16'sd5, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_CREATE, 6'd2, 1'b0, 6'd50, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_TICK, 6'd1, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_TICK, 6'd1, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_TICK, 6'd2, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_RESTART, 6'd0, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_SECOND, 6'd0, 1'b0, 6'd0, 16'sd0, 7'd127, 1'b0, '0},
      '{mlfq_pkg::K_SECOND, 6'd1, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_SECOND, 6'd1, 1'b0, 6'd0, 16'sd0, 7'd64, 1'b0, '0},
      '{mlfq_pkg::K_EXIT, 6'd2, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_TICK, 6'd2, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{K_UNUSED, 6'd1, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_SET_NICE, 6'd0, 1'b0, 6'd0, -16'sd1, 7'd0, 1'b0, '0},
      '{mlfq_pkg::K_QUERY, 6'd0, 1'b0, 6'd0, 16'sd0, 7'd0, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_config(phases[0]);
    foreach (directed[i]) issue_event(directed[i]);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        drain();
        apply_config(phases[p]);
      end
      // One phase runs with both channels streaming without gaps.
      calm = (p == 3);
      repeat (95) issue_event(random_event());
    end
    calm = 1'b0;
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
